>>> src/ptc_pkg.sv
`timescale 1ns / 1ps
package ptc_pkg;

   localparam int unsigned NumRegs  = 5;
   localparam int unsigned CsrIdxW  = 3;
   localparam int unsigned DivSteps = 32;
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueuePtrW  = 2;

   typedef enum logic [CsrIdxW-1:0] {
      REG_AC1_AC2 = 3'd0,
      REG_AC3_AC4 = 3'd1,
      REG_AC5_AC6 = 3'd2,
      REG_B1_B2   = 3'd3,
      REG_MC_MD   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [15:0] raw_temperature;
      logic [15:0] raw_pressure;
   } req_type;

   typedef struct packed {
      logic signed [31:0] temperature_decideg;
      logic signed [31:0] pressure_pa;
      logic               div_error;
   } rsp_type;

   typedef struct packed {
      logic [31:0] ac1;
      logic [31:0] ac2;
      logic [31:0] ac3;
      logic [31:0] ac4;
      logic [31:0] ac5;
      logic [31:0] ac6;
      logic [31:0] b1;
      logic [31:0] b2;
      logic [31:0] mc;
      logic [31:0] md;
   } coef_type;

   typedef struct packed {
      logic        num_neg;
      logic        den_neg;
      logic        shift_after;
      logic        zero;
      logic [31:0] num;
      logic [31:0] den;
   } div_op_type;

   function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned s);
      asr32 = 32'($signed(x) >>> s);
   endfunction

   function automatic logic [31:0] sx16(input logic [15:0] v);
      sx16 = {{16{v[15]}}, v};
   endfunction

endpackage

>>> src/ptc_if.sv
`timescale 1ns / 1ps
interface ptc_req_if;
   logic             valid;
   logic             ready;
   ptc_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ptc_rsp_if;
   logic             valid;
   logic             ready;
   ptc_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> src/ptc_divider.sv
`timescale 1ns / 1ps
module ptc_divider (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                in_valid,
   input  logic [31:0]         in_num,
   input  logic [31:0]         in_den,
   input  logic                in_neg,
   input  logic                in_zero,
   input  logic [95:0]         in_tag,
   output logic                out_valid,
   output logic [31:0]         out_quot,
   output logic                out_neg,
   output logic                out_zero,
   output logic [95:0]         out_tag
);
   import ptc_pkg::*;

   // One restoring quotient bit per stage; unsigned magnitudes.
   logic [DivSteps:0]       valid_ff;
   logic [31:0]             rem_ff  [DivSteps+1];
   logic [31:0]             num_ff  [DivSteps+1];
   logic [31:0]             den_ff  [DivSteps+1];
   logic                    neg_ff  [DivSteps+1];
   logic                    zero_ff [DivSteps+1];
   logic [95:0]             tag_ff  [DivSteps+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[DivSteps-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0]  <= '0;
         num_ff[0]  <= in_num;
         den_ff[0]  <= in_den;
         neg_ff[0]  <= in_neg;
         zero_ff[0] <= in_zero;
         tag_ff[0]  <= in_tag;
      end
   end

   for (genvar g = 0; g < DivSteps; g++) begin : g_step
      logic [32:0] trial;
      logic [32:0] shifted;
      always_comb begin
         shifted = {rem_ff[g], num_ff[g][31]};
         trial   = shifted - {1'b0, den_ff[g]};
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[g+1]  <= trial[32] ? shifted[31:0] : trial[31:0];
            num_ff[g+1]  <= {num_ff[g][30:0], ~trial[32]};
            den_ff[g+1]  <= den_ff[g];
            neg_ff[g+1]  <= neg_ff[g];
            zero_ff[g+1] <= zero_ff[g];
            tag_ff[g+1]  <= tag_ff[g];
         end
      end
   end

   assign out_valid = valid_ff[DivSteps];
   assign out_quot  = num_ff[DivSteps];
   assign out_neg   = neg_ff[DivSteps];
   assign out_zero  = zero_ff[DivSteps];
   assign out_tag   = tag_ff[DivSteps];

endmodule

>>> src/ptc_front.sv
`timescale 1ns / 1ps
module ptc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic               in_valid,
   input  ptc_pkg::req_type   in_req,
   input  ptc_pkg::coef_type  coef,
   output logic               out_valid,
   output ptc_pkg::rsp_type   out_rsp
);
   import ptc_pkg::*;

   // Stage 1: x1 product.
   logic        v1_ff;
   logic [31:0] prod1_ff;
   logic [15:0] up1_ff;
   // Stage 2: temperature divisor.
   logic        v2_ff;
   logic [31:0] x1_2_ff;
   logic [31:0] den2_ff;
   logic [15:0] up2_ff;
   // Temperature divider output and the stages after it.
   logic        tq_valid;
   logic [31:0] tq_quot;
   logic        tq_neg;
   logic        tq_zero;
   logic [95:0] tq_tag;
   logic        v3_ff;
   logic [31:0] b5_3_ff;
   logic        z3_ff;
   logic [15:0] up3_ff;
   logic        v4_ff;
   logic [31:0] b5_4_ff;
   logic [31:0] b6_4_ff;
   logic [31:0] b6sq_4_ff;
   logic        z4_ff;
   logic [15:0] up4_ff;
   logic        v5_ff;
   logic [31:0] b5_5_ff;
   logic [31:0] b6_5_ff;
   logic [31:0] sq_5_ff;
   logic        z5_ff;
   logic [15:0] up5_ff;
   logic        v6_ff;
   logic [31:0] b5_6_ff;
   logic [31:0] p_b2_ff;
   logic [31:0] p_ac2_ff;
   logic [31:0] p_ac3_ff;
   logic [31:0] p_b1_ff;
   logic        z6_ff;
   logic [15:0] up6_ff;
   logic        v7_ff;
   logic [31:0] b5_7_ff;
   logic [31:0] b3_7_ff;
   logic [31:0] x3_7_ff;
   logic        z7_ff;
   logic [15:0] up7_ff;
   logic        v8_ff;
   logic [31:0] b5_8_ff;
   logic [31:0] b4_8_ff;
   logic [31:0] b7_8_ff;
   logic        z8_ff;
   // Pressure divider output and the polynomial stages.
   logic        pq_valid;
   logic [31:0] pq_quot;
   logic        pq_neg;
   logic        pq_zero;
   logic [95:0] pq_tag;
   logic        v9_ff;
   logic [31:0] p9_ff;
   logic [31:0] temp9_ff;
   logic        z9_ff;
   logic        v10_ff;
   logic [31:0] p10_ff;
   logic [31:0] pp10_ff;
   logic [31:0] p7357_10_ff;
   logic [31:0] temp10_ff;
   logic        z10_ff;
   logic        v11_ff;
   logic [31:0] p11_ff;
   logic [31:0] x1m_11_ff;
   logic [31:0] p7357_11_ff;
   logic [31:0] temp11_ff;
   logic        z11_ff;

   logic [31:0] ut_ext;
   logic [31:0] den_in;
   logic [31:0] mc_sh;
   logic [31:0] x2_in;
   logic [31:0] b5_in;
   logic [31:0] b6_in;
   logic [31:0] x3a_in;
   logic [31:0] b3_in;
   logic [31:0] x3b_in;
   logic [31:0] b4_in;
   logic [31:0] b7_in;
   logic [31:0] b4_prod;
   logic [31:0] pnum;
   logic [31:0] p_in;
   logic [31:0] temp_in;
   logic [31:0] pres_in;

   always_comb begin
      ut_ext  = {16'd0, in_req.raw_temperature};
      den_in  = asr32(prod1_ff, 15) + coef.md;
      mc_sh   = {coef.mc[20:0], 11'd0};
      x2_in   = tq_neg ? (32'd0 - tq_quot) : tq_quot;
      b5_in   = tq_tag[63:32] + x2_in;
      b6_in   = b5_3_ff - 32'd4000;
      x3a_in  = asr32(p_b2_ff, 11) + asr32(p_ac2_ff, 11);
      b3_in   = asr32((coef.ac1 << 2) + x3a_in + 32'd2, 2);
      x3b_in  = asr32(asr32(p_ac3_ff, 13) + asr32(p_b1_ff, 16) + 32'd2, 2);
      b4_prod = coef.ac4 * (x3_7_ff + 32'd32768);
      b4_in   = {15'd0, b4_prod[31:15]};
      b7_in   = ({16'd0, up7_ff} - b3_7_ff) * 32'd50000;
      pnum    = b7_8_ff[31] ? b7_8_ff : (b7_8_ff << 1);
      p_in    = pq_neg ? (pq_quot << 1) : pq_quot;
      temp_in = asr32(pq_tag[95:64] + 32'd8, 4);
      pres_in = p11_ff
              + asr32(asr32(x1m_11_ff, 16) + asr32(p7357_11_ff, 16) + 32'd3791, 4);
   end

   // The temperature divider carries x1 and UP in its tag; the pressure
   // divider reuses the neg bit to mean "shift the quotient afterwards".
   ptc_divider u_tdiv (
      .clock(clock), .reset(reset), .enable(enable),
      .in_valid(v2_ff),
      .in_num(mc_sh[31] ? (32'd0 - mc_sh) : mc_sh),
      .in_den(den2_ff[31] ? (32'd0 - den2_ff) : den2_ff),
      .in_neg(mc_sh[31] != den2_ff[31]),
      .in_zero(den2_ff == 32'd0),
      .in_tag({32'd0, x1_2_ff, 16'd0, up2_ff}),
      .out_valid(tq_valid), .out_quot(tq_quot), .out_neg(tq_neg),
      .out_zero(tq_zero), .out_tag(tq_tag)
   );

   ptc_divider u_pdiv (
      .clock(clock), .reset(reset), .enable(enable),
      .in_valid(v8_ff),
      .in_num(pnum),
      .in_den(b4_8_ff),
      .in_neg(b7_8_ff[31]),
      .in_zero(z8_ff || (b4_8_ff == 32'd0)),
      .in_tag({b5_8_ff, 32'd0, 32'd0}),
      .out_valid(pq_valid), .out_quot(pq_quot), .out_neg(pq_neg),
      .out_zero(pq_zero), .out_tag(pq_tag)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;
         v6_ff  <= 1'b0;
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
         v11_ff <= 1'b0;
      end else if (enable) begin
         v1_ff  <= in_valid;
         v2_ff  <= v1_ff;
         v3_ff  <= tq_valid;
         v4_ff  <= v3_ff;
         v5_ff  <= v4_ff;
         v6_ff  <= v5_ff;
         v7_ff  <= v6_ff;
         v8_ff  <= v7_ff;
         v9_ff  <= pq_valid;
         v10_ff <= v9_ff;
         v11_ff <= v10_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod1_ff    <= (ut_ext - coef.ac6) * coef.ac5;
         up1_ff      <= in_req.raw_pressure;
         x1_2_ff     <= asr32(prod1_ff, 15);
         den2_ff     <= den_in;
         up2_ff      <= up1_ff;
         b5_3_ff     <= b5_in;
         z3_ff       <= tq_zero;
         up3_ff      <= tq_tag[15:0];
         b5_4_ff     <= b5_3_ff;
         b6_4_ff     <= b6_in;
         b6sq_4_ff   <= b6_in * b6_in;
         z4_ff       <= z3_ff;
         up4_ff      <= up3_ff;
         b5_5_ff     <= b5_4_ff;
         b6_5_ff     <= b6_4_ff;
         sq_5_ff     <= asr32(b6sq_4_ff, 12);
         z5_ff       <= z4_ff;
         up5_ff      <= up4_ff;
         b5_6_ff     <= b5_5_ff;
         p_b2_ff     <= coef.b2 * sq_5_ff;
         p_ac2_ff    <= coef.ac2 * b6_5_ff;
         p_ac3_ff    <= coef.ac3 * b6_5_ff;
         p_b1_ff     <= coef.b1 * sq_5_ff;
         z6_ff       <= z5_ff;
         up6_ff      <= up5_ff;
         b5_7_ff     <= b5_6_ff;
         b3_7_ff     <= b3_in;
         x3_7_ff     <= x3b_in;
         z7_ff       <= z6_ff;
         up7_ff      <= up6_ff;
         b5_8_ff     <= b5_7_ff;
         b4_8_ff     <= b4_in;
         b7_8_ff     <= b7_in;
         z8_ff       <= z7_ff;
         p9_ff       <= p_in;
         temp9_ff    <= temp_in;
         z9_ff       <= pq_zero;
         p10_ff      <= p9_ff;
         pp10_ff     <= asr32(p9_ff, 8) * asr32(p9_ff, 8);
         p7357_10_ff <= (32'd0 - 32'd7357) * p9_ff;
         temp10_ff   <= temp9_ff;
         z10_ff      <= z9_ff;
         p11_ff      <= p10_ff;
         x1m_11_ff   <= asr32(pp10_ff * 32'd3038, 0);
         p7357_11_ff <= p7357_10_ff;
         temp11_ff   <= temp10_ff;
         z11_ff      <= z10_ff;
      end
   end

   assign out_valid                   = v11_ff;
   assign out_rsp.temperature_decideg = z11_ff ? 32'sd0 : $signed(temp11_ff);
   assign out_rsp.pressure_pa         = z11_ff ? 32'sd0 : $signed(pres_in);
   assign out_rsp.div_error           = z11_ff;

endmodule

>>> src/ptc_back.sv
`timescale 1ns / 1ps
module ptc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  ptc_pkg::rsp_type  in_rsp,
   output logic              almost_full,
   ptc_rsp_if.source         rsp
);
   import ptc_pkg::*;

   logic [QueuePtrW-1:0] wr_ptr_ff;
   logic [QueuePtrW-1:0] wr_ptr_in;
   logic [QueuePtrW-1:0] rd_ptr_ff;
   logic [QueuePtrW-1:0] rd_ptr_in;
   logic [QueuePtrW:0]   count_ff;
   logic [QueuePtrW:0]   count_in;
   rsp_type              mem_ff [QueueDepth];
   logic                 push;
   logic                 pop;

   always_comb begin
      push      = in_valid;
      pop       = rsp.valid && rsp.ready;
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + {{QueuePtrW{1'b0}}, push} - {{QueuePtrW{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_rsp;
      end
   end

   assign almost_full = count_ff >= (QueuePtrW+1)'(QueueDepth - 1);
   assign rsp.valid   = count_ff != '0;
   assign rsp.payload = mem_ff[rd_ptr_ff];

endmodule

>>> src/pressure_temp_compensation_core.sv
`timescale 1ns / 1ps
// Pressure and temperature compensation for oversampling setting 0. One raw
// reading pair is accepted per cycle unless stalled; each result passes through
// two 32-stage pipelined dividers in series before it can be taken. The
// datapath advances as a whole and holds while the small result queue is
// nearly full. A zero divisor gives zero results with div_error set.
module pressure_temp_compensation_core (
   input  logic                             clock,
   input  logic                             reset,
   ptc_req_if.sink                          req,
   ptc_rsp_if.source                        rsp,
   input  logic                             csr_write_enable,
   input  logic [ptc_pkg::CsrIdxW-1:0]      csr_index,
   input  logic [31:0]                      csr_write_data
);
   import ptc_pkg::*;

   logic [31:0] regs_ff [NumRegs];
   coef_type    coef;
   logic        almost_full;
   logic        enable;
   logic        front_valid;
   rsp_type     front_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumRegs; i++) begin
            regs_ff[i] <= '0;
         end
      end else if (csr_write_enable && (csr_index < CsrIdxW'(NumRegs))) begin
         regs_ff[csr_index] <= csr_write_data;
      end
   end

   always_comb begin
      coef.ac1 = sx16(regs_ff[REG_AC1_AC2][31:16]);
      coef.ac2 = sx16(regs_ff[REG_AC1_AC2][15:0]);
      coef.ac3 = sx16(regs_ff[REG_AC3_AC4][31:16]);
      coef.ac4 = {16'd0, regs_ff[REG_AC3_AC4][15:0]};
      coef.ac5 = {16'd0, regs_ff[REG_AC5_AC6][31:16]};
      coef.ac6 = {16'd0, regs_ff[REG_AC5_AC6][15:0]};
      coef.b1  = sx16(regs_ff[REG_B1_B2][31:16]);
      coef.b2  = sx16(regs_ff[REG_B1_B2][15:0]);
      coef.mc  = sx16(regs_ff[REG_MC_MD][31:16]);
      coef.md  = sx16(regs_ff[REG_MC_MD][15:0]);
   end

   assign enable    = !almost_full;
   assign req.ready = enable;

   ptc_front u_front (
      .clock(clock), .reset(reset), .enable(enable),
      .in_valid(req.valid && enable), .in_req(req.payload), .coef(coef),
      .out_valid(front_valid), .out_rsp(front_rsp)
   );

   ptc_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(front_valid && enable), .in_rsp(front_rsp),
      .almost_full(almost_full), .rsp(rsp)
   );

`ifndef SYNTHESIS
   a_error_zeroes: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.payload.div_error) |->
      (rsp.payload.temperature_decideg == 0 && rsp.payload.pressure_pa == 0))
      else $error("error result carries nonzero values");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      almost_full |-> !req.ready)
      else $error("request taken while queue nearly full");
`endif

endmodule

>>> dv/pressure_temp_compensation_core_test.sv
`timescale 1ns / 1ps
module pressure_temp_compensation_core_test;
   import ptc_pkg::*;

   localparam int unsigned WatchdogLimit = 20000;
   localparam int unsigned DrainCycles   = 200;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CsrIdxW-1:0] csr_index;
   logic [31:0] csr_write_data;

   ptc_req_if req_ch ();
   ptc_rsp_if rsp_ch ();

   pressure_temp_compensation_core uut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch.sink),
      .rsp              (rsp_ch.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   typedef struct {
      logic [15:0] ut;
      logic [15:0] up;
      logic        typed;
      rsp_type     result;
   } stim_row_type;

   logic [31:0] cal_shadow [NumRegs];
   rsp_type     pending_results [$];
   int unsigned error_count;
   int unsigned idle_cycles;
   int unsigned rsp_gap;
   bit          rsp_hold_long;
   bit          stimulus_done;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [31:0] shr_s(input logic [31:0] x, input int unsigned s);
      shr_s = 32'($signed(x) >>> s);
   endfunction

   function automatic logic [31:0] ext16(input logic [15:0] v);
      ext16 = {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] quot_signed(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] ma;
      logic [31:0] mb;
      logic [31:0] q;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q = ma / mb;
      quot_signed = (a[31] != b[31]) ? -q : q;
   endfunction

   function automatic rsp_type compensate(input logic [15:0] ut_in, input logic [15:0] up_in);
      logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, p, sq, den;
      rsp_type r;
      ac1 = ext16(cal_shadow[REG_AC1_AC2][31:16]);
      ac2 = ext16(cal_shadow[REG_AC1_AC2][15:0]);
      ac3 = ext16(cal_shadow[REG_AC3_AC4][31:16]);
      ac4 = {16'd0, cal_shadow[REG_AC3_AC4][15:0]};
      ac5 = {16'd0, cal_shadow[REG_AC5_AC6][31:16]};
      ac6 = {16'd0, cal_shadow[REG_AC5_AC6][15:0]};
      b1 = ext16(cal_shadow[REG_B1_B2][31:16]);
      b2 = ext16(cal_shadow[REG_B1_B2][15:0]);
      mc = ext16(cal_shadow[REG_MC_MD][31:16]);
      md = ext16(cal_shadow[REG_MC_MD][15:0]);
      r = '0;
      x1 = shr_s(({16'd0, ut_in} - ac6) * ac5, 15);
      den = x1 + md;
      if (den == 32'd0) begin
         r.div_error = 1'b1;
         return r;
      end
      x2 = quot_signed(mc << 11, den);
      b5 = x1 + x2;
      r.temperature_decideg = shr_s(b5 + 32'd8, 4);
      b6 = b5 - 32'd4000;
      sq = shr_s(b6 * b6, 12);
      x1 = shr_s(b2 * sq, 11);
      x2 = shr_s(ac2 * b6, 11);
      x3 = x1 + x2;
      b3 = shr_s(ac1 * 32'd4 + x3 + 32'd2, 2);
      x1 = shr_s(ac3 * b6, 13);
      x2 = shr_s(b1 * sq, 16);
      x3 = shr_s(x1 + x2 + 32'd2, 2);
      b4 = (ac4 * (x3 + 32'd32768)) >> 15;
      if (b4 == 32'd0) begin
         r = '0;
         r.div_error = 1'b1;
         return r;
      end
      b7 = ({16'd0, up_in} - b3) * 32'd50000;
      if (!b7[31]) begin
         p = (b7 << 1) / b4;
      end else begin
         p = (b7 / b4) << 1;
      end
      x1 = shr_s(p, 8) * shr_s(p, 8);
      x1 = shr_s(x1 * 32'd3038, 16);
      x2 = shr_s(-32'd7357 * p, 16);
      r.pressure_pa = p + shr_s(x1 + x2 + 32'd3791, 4);
      return r;
   endfunction

   task automatic write_cal(input csr_index_type idx, input logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cal_shadow[idx] = value;
   endtask

   task automatic load_calibration(input logic [31:0] v0, input logic [31:0] v1,
                                   input logic [31:0] v2, input logic [31:0] v3,
                                   input logic [31:0] v4);
      write_cal(REG_AC1_AC2, v0);
      write_cal(REG_AC3_AC4, v1);
      write_cal(REG_AC5_AC6, v2);
      write_cal(REG_B1_B2, v3);
      write_cal(REG_MC_MD, v4);
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic send_reading(input logic [15:0] ut_in, input logic [15:0] up_in,
                               input bit gaps);
      if (gaps && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat (($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                              : $urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= '{raw_temperature: ut_in, raw_pressure: up_in};
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_results.push_back(compensate(ut_in, up_in));
   endtask

   task automatic run_rows(input stim_row_type list [$]);
      foreach (list[i]) begin
         send_reading(list[i].ut, list[i].up, 1'b0);
         if (list[i].typed) begin
            if (pending_results[$] !== list[i].result) begin
               $error("result: expected %p, actual %p", list[i].result,
                      pending_results[$]);
               error_count++;
            end
            pending_results[$] = list[i].result;
         end
      end
      req_ch.valid <= 1'b0;
   endtask

   task automatic run_random(input int unsigned count, input bit typical);
      logic [15:0] ut;
      logic [15:0] up;
      for (int unsigned i = 0; i < count; i++) begin
         if (typical) begin
            ut = 16'($urandom_range(20000, 36000));
            up = 16'($urandom_range(15000, 50000));
         end else begin
            ut = 16'($urandom);
            up = 16'($urandom);
         end
         send_reading(ut, up, (i / 100) % 2 == 0);
      end
      req_ch.valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            $error("Unexpected result: %p", rsp_ch.payload);
            error_count++;
         end else begin
            rsp_type want;
            want = pending_results.pop_front();
            if (rsp_ch.payload.temperature_decideg !== want.temperature_decideg) begin
               $error("temperature_decideg: expected %0d, actual %0d",
                      want.temperature_decideg, rsp_ch.payload.temperature_decideg);
               error_count++;
            end
            if (rsp_ch.payload.pressure_pa !== want.pressure_pa) begin
               $error("pressure_pa: expected %0d, actual %0d",
                      want.pressure_pa, rsp_ch.payload.pressure_pa);
               error_count++;
            end
            if (rsp_ch.payload.div_error !== want.div_error) begin
               $error("div_error: expected %0b, actual %0b",
                      want.div_error, rsp_ch.payload.div_error);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_gap <= 0;
      end else if (rsp_hold_long) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_gap != 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_gap <= rsp_gap - 1;
      end else if ($urandom_range(0, 49) == 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_gap <= $urandom_range(10, 40);
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 9) < 7);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      rsp_hold_long = 1'b0;
      wait (stimulus_done == 1'b0);
      @(posedge clock);
      wait (pending_results.size() > 30);
      rsp_hold_long = 1'b1;
      repeat (300) @(posedge clock);
      rsp_hold_long = 1'b0;
   end

   initial begin
      stim_row_type rows [$];
      stimulus_done = 1'b0;
      error_count = 0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      for (int i = 0; i < NumRegs; i++) cal_shadow[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // With all coefficients zero, the temperature divisor is zero.
      rows.push_back('{16'h0000, 16'h0000, 1'b1, '{32'sd0, 32'sd0, 1'b1}});
      rows.push_back('{16'hFFFF, 16'hFFFF, 1'b1, '{32'sd0, 32'sd0, 1'b1}});
      run_rows(rows);
      wait_drained();

      // Typical datasheet calibration.
      load_calibration({16'd408, -16'sd72}, {-16'sd14383, 16'd32741},
                       {16'd32757, 16'd23153}, {16'd6190, 16'd4},
                       {-16'sd8711, 16'd2868});
      rows.delete();
      rows.push_back('{16'd27898, 16'd23843, 1'b0, '0});
      rows.push_back('{16'h0000, 16'h0000, 1'b0, '0});
      rows.push_back('{16'hFFFF, 16'hFFFF, 1'b0, '0});
      rows.push_back('{16'h0000, 16'hFFFF, 1'b0, '0});
      rows.push_back('{16'hFFFF, 16'h0000, 1'b0, '0});
      rows.push_back('{16'h5555, 16'hAAAA, 1'b0, '0});
      rows.push_back('{16'hAAAA, 16'h5555, 1'b0, '0});
      run_rows(rows);
      wait_drained();

      // Zero ac4 forces the pressure divisor to zero.
      load_calibration({16'd408, -16'sd72}, {-16'sd14383, 16'd0},
                       {16'd32757, 16'd23153}, {16'd6190, 16'd4},
                       {-16'sd8711, 16'd2868});
      rows.delete();
      rows.push_back('{16'd27898, 16'd23843, 1'b1, '{32'sd0, 32'sd0, 1'b1}});
      rows.push_back('{16'hFFFF, 16'h0000, 1'b1, '{32'sd0, 32'sd0, 1'b1}});
      run_rows(rows);
      wait_drained();

      // Negative numerator over minus one: mc << 11 is -2^23, divisor -1.
      load_calibration(32'h8000_7FFF, 32'h8000_FFFF, 32'h0000_0000,
                       32'h7FFF_8000, 32'hF000_FFFF);
      send_reading(16'd0, 16'd0, 1'b0);
      req_ch.valid <= 1'b0;
      wait_drained();

      // Typical calibration with the long receiver stall.
      load_calibration({16'd408, -16'sd72}, {-16'sd14383, 16'd32741},
                       {16'd32757, 16'd23153}, {16'd6190, 16'd4},
                       {-16'sd8711, 16'd2868});
      run_random(700, 1'b1);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         if (phase == 3) begin
            load_calibration(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF, 32'hFFFF_FFFF);
         end else begin
            load_calibration($urandom, $urandom, $urandom, $urandom, $urandom);
         end
         run_random(300, 1'b0);
         wait_drained();
      end

      stimulus_done = 1'b1;
      wait_drained();
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

>>> filelist.f
src/ptc_pkg.sv
src/ptc_if.sv
src/ptc_divider.sv
src/ptc_front.sv
src/ptc_back.sv
src/pressure_temp_compensation_core.sv
dv/pressure_temp_compensation_core_test.sv
